// ===== rtl/asc_pkg.sv =====
`default_nettype none
package asc_pkg;

	// smoothing window
	localparam int unsigned SMOOTH_TAPS = 5;
	localparam int unsigned HALF_TAPS   = SMOOTH_TAPS / 2;
	localparam int unsigned SMOOTH_DIV  = (HALF_TAPS + 1) * (HALF_TAPS + 1);
	localparam int unsigned TAP_AW      = $clog2(SMOOTH_TAPS);
	localparam int unsigned W_W         = $clog2(HALF_TAPS + 2);
	localparam int unsigned SM_ACC_W    = 16 + $clog2(SMOOTH_DIV);
	// reciprocal for the divide by SMOOTH_DIV, error under one count
	localparam int unsigned RECIP_SHIFT = SM_ACC_W + 4;
	localparam logic [RECIP_SHIFT-1:0] SM_RECIP =
		RECIP_SHIFT'((64'd1 << RECIP_SHIFT) / SMOOTH_DIV);

	// history ring
	localparam int unsigned HISTORY_DEPTH = 32;
	localparam int unsigned HIST_AW       = $clog2(HISTORY_DEPTH);
	localparam int unsigned DUR_W         = HIST_AW + 1;

	// configuration
	localparam int unsigned CFG_IDX_W  = 2;
	localparam int unsigned CFG_DATA_W = 12;
	localparam logic [CFG_IDX_W-1:0] CFG_INTERVAL_MIN = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_INTERVAL_MAX = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_AMP_FLOOR    = 2'd2;
	localparam logic [7:0]  INTERVAL_MIN_RST = 8'd10;
	localparam logic [7:0]  INTERVAL_MAX_RST = 8'd100;
	localparam logic [11:0] AMP_FLOOR_RST    = 12'd3;

	localparam logic [2:0] INC_NONE  = 3'd0;
	localparam logic [2:0] INC_ONE   = 3'd1;
	localparam logic [2:0] INC_SEVEN = 3'd7;

	typedef struct packed {
		logic [7:0]  interval_min;
		logic [7:0]  interval_max;
		logic [11:0] amp_floor;
	} cfg_t;

	// triangular weight of tap i, counted from the oldest sample
	function automatic logic [W_W-1:0] tap_weight(input logic [TAP_AW-1:0] i);
		int unsigned a;
		int unsigned b;
		a = int'(i) + 1;
		b = SMOOTH_TAPS - int'(i);
		return (a < b) ? W_W'(a) : W_W'(b);
	endfunction

endpackage
`default_nettype wire

// ===== rtl/asc_mag.sv =====
`default_nettype none
module asc_mag import asc_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	input  wire logic [15:0] accel_x,
	input  wire logic [15:0] accel_y,
	input  wire logic [15:0] accel_z,
	output logic             done,
	output logic [15:0]      magnitude
);

	typedef enum logic [2:0] {
		M_IDLE = 3'b001,
		M_SQ   = 3'b010,
		M_ROOT = 3'b100
	} mstate_t;

	mstate_t     state_q;
	logic [47:0] axes_q;
	logic [1:0]  axis_q;
	logic [3:0]  iter_q;
	logic [31:0] sum_q;
	logic [32:0] rem_q, root_q, bit_q;

	logic [15:0] v;
	logic [16:0] a;
	logic [33:0] sq;
	logic [32:0] trial;

	always_comb begin
		unique case (axis_q)
			2'd0:    v = axes_q[15:0];
			2'd1:    v = axes_q[31:16];
			default: v = axes_q[47:32];
		endcase
		a     = v[15] ? (17'h10000 - {1'b0, v}) : {1'b0, v};
		sq    = a * a;
		trial = root_q + bit_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= M_IDLE;
			axis_q  <= '0;
			iter_q  <= '0;
			done    <= 1'b0;
		end else begin
			done <= 1'b0;
			unique case (state_q)
				M_IDLE: begin
					if (start) begin
						axis_q  <= '0;
						state_q <= M_SQ;
					end
				end
				M_SQ: begin
					axis_q <= axis_q + 2'd1;
					if (axis_q == 2'd2) begin
						iter_q  <= '0;
						state_q <= M_ROOT;
					end
				end
				M_ROOT: begin
					iter_q <= iter_q + 4'd1;
					if (iter_q == 4'd15) begin
						done    <= 1'b1;
						state_q <= M_IDLE;
					end
				end
				default: state_q <= M_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == M_IDLE && start) begin
			axes_q <= {accel_z, accel_y, accel_x};
			sum_q  <= '0;
		end else if (state_q == M_SQ) begin
			sum_q <= sum_q + sq[31:0];
			if (axis_q == 2'd2) begin
				rem_q  <= {1'b0, sum_q + sq[31:0]};
				root_q <= '0;
				bit_q  <= 33'h040000000;
			end
		end else if (state_q == M_ROOT) begin
			if (rem_q >= trial) begin
				rem_q  <= rem_q - trial;
				root_q <= (root_q + (bit_q << 1)) >> 1;
			end else begin
				root_q <= root_q >> 1;
			end
			bit_q <= bit_q >> 2;
		end
	end

	assign magnitude = root_q[15:0];

endmodule
`default_nettype wire

// ===== rtl/asc_smooth.sv =====
`default_nettype none
module asc_smooth import asc_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	input  wire logic [15:0] magnitude,
	output logic             done,
	output logic [15:0]      smoothed
);

	typedef enum logic [3:0] {
		S_IDLE = 4'b0001,
		S_MAC  = 4'b0010,
		S_MUL  = 4'b0100,
		S_FIX  = 4'b1000
	} sstate_t;

	sstate_t                       state_q;
	logic [15:0]                   ring_q [SMOOTH_TAPS];
	logic [TAP_AW-1:0]             pos_q, idx_q, tap_q;
	logic [SM_ACC_W-1:0]           acc_q;
	logic [SM_ACC_W+RECIP_SHIFT-1:0] prod_q;
	logic [15:0]                   sm_q;

	logic [SM_ACC_W-1:0] q0;
	logic [SM_ACC_W-1:0] back;
	logic [TAP_AW-1:0]   pos_nx;

	always_comb begin
		q0     = prod_q[RECIP_SHIFT +: SM_ACC_W];
		back   = SM_ACC_W'(q0 * SMOOTH_DIV);
		pos_nx = (pos_q == TAP_AW'(SMOOTH_TAPS - 1)) ? '0 : pos_q + 1'b1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			pos_q   <= '0;
			idx_q   <= '0;
			tap_q   <= '0;
			done    <= 1'b0;
			for (int i = 0; i < SMOOTH_TAPS; i++) begin
				ring_q[i] <= '0;
			end
		end else begin
			done <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (start) begin
						ring_q[pos_q] <= magnitude;
						idx_q         <= pos_nx;
						tap_q         <= '0;
						state_q       <= S_MAC;
					end
				end
				S_MAC: begin
					idx_q <= (idx_q == TAP_AW'(SMOOTH_TAPS - 1)) ? '0 : idx_q + 1'b1;
					tap_q <= tap_q + 1'b1;
					if (tap_q == TAP_AW'(SMOOTH_TAPS - 1)) state_q <= S_MUL;
				end
				S_MUL: state_q <= S_FIX;
				S_FIX: begin
					pos_q   <= pos_nx;
					done    <= 1'b1;
					state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && start) begin
			acc_q <= '0;
		end else if (state_q == S_MAC) begin
			acc_q <= acc_q + SM_ACC_W'(ring_q[idx_q] * tap_weight(tap_q));
		end else if (state_q == S_MUL) begin
			prod_q <= acc_q * SM_RECIP;
		end else if (state_q == S_FIX) begin
			// reciprocal estimate is low by at most one
			if (acc_q - back >= SM_ACC_W'(SMOOTH_DIV)) sm_q <= 16'(q0 + 1'b1);
			else sm_q <= q0[15:0];
		end
	end

	assign smoothed = sm_q;

endmodule
`default_nettype wire

// ===== rtl/asc_detect.sv =====
`default_nettype none
module asc_detect import asc_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	input  wire logic [15:0] smoothed,
	input  wire cfg_t        cfg,
	output logic             done,
	output logic [2:0]       step_increment
);

	typedef enum logic [5:0] {
		D_IDLE = 6'b000001,
		D_WR   = 6'b000010,
		D_RA   = 6'b000100,
		D_RB   = 6'b001000,
		D_RC   = 6'b010000,
		D_CALC = 6'b100000
	} dstate_t;

	dstate_t              state_q;
	logic [15:0]          hist_mem [HISTORY_DEPTH];
	logic [HISTORY_DEPTH-1:0] valid_q;
	logic [15:0]          rd_q;
	logic                 rv_q;
	logic [HIST_AW-1:0]   spos_q, peak_q, valley_q;
	logic [15:0]          sm_q, prev_q, pk_q, vl_q;
	logic                 up_q;
	logic [3:0]           good_q;
	logic [7:0]           miss_q;
	logic [7:0]           lo_q, hi_q;
	logic [2:0]           inc_q;

	logic [HIST_AW-1:0] this_i, spos_nx, rd_addr;
	logic [15:0]        rd_val;
	logic [11:0]        now12, prev12, pk12, vl12;
	logic [15:0]        p2v, v2p;
	logic               up_nx, turn, pass;
	logic [DUR_W-1:0]   dur;
	logic [10:0]        dur_x, hi5;
	logic [21:0]        lo_p;
	logic               in_win;
	logic [3:0]         good_nx;
	logic [7:0]         miss_nx;

	always_comb begin
		this_i  = (spos_q == '0) ? HIST_AW'(HISTORY_DEPTH - 1) : spos_q - 1'b1;
		spos_nx = (spos_q == HIST_AW'(HISTORY_DEPTH - 1)) ? '0 : spos_q + 1'b1;
		unique case (state_q)
			D_WR:    rd_addr = this_i;
			D_RA:    rd_addr = peak_q;
			default: rd_addr = valley_q;
		endcase
		rd_val = rv_q ? rd_q : '0;

		now12  = sm_q[15:4];
		prev12 = prev_q[15:4];
		pk12   = pk_q[15:4];
		vl12   = vl_q[15:4];
		// swings wrap at 16 bits
		p2v    = {4'd0, pk12} - {4'd0, vl12};
		v2p    = {4'd0, prev12} - {4'd0, vl12};
		up_nx  = now12 > prev12;
		turn   = (prev12 != now12) && (up_q == (prev12 > now12));
		pass   = turn && !((p2v >> 2) > v2p) && (v2p > {4'd0, cfg.amp_floor});

		if (this_i > peak_q) dur = DUR_W'(this_i - peak_q);
		else dur = DUR_W'({1'b0, this_i} + DUR_W'(HISTORY_DEPTH) - {1'b0, peak_q});
		dur_x  = 11'(dur);
		hi5    = 11'((dur_x * 11'd5) >> 2);
		lo_p   = 22'(dur_x) * 22'd13108; // 4/5 as 4*3277 / 2^14
		in_win = (dur_x > {3'd0, lo_q}) && (dur_x < {3'd0, hi_q});
		good_nx = (good_q == 4'd15) ? good_q : good_q + 4'd1;
		miss_nx = (miss_q == 8'd255) ? miss_q : miss_q + 8'd1;
	end

	always_ff @(posedge clk) begin
		if (state_q == D_WR) hist_mem[spos_q] <= sm_q;
		rd_q <= hist_mem[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= D_IDLE;
			valid_q  <= '0;
			rv_q     <= 1'b0;
			spos_q   <= '0;
			peak_q   <= '0;
			valley_q <= '0;
			up_q     <= 1'b0;
			good_q   <= '0;
			miss_q   <= '0;
			lo_q     <= INTERVAL_MIN_RST;
			hi_q     <= INTERVAL_MAX_RST;
			inc_q    <= INC_NONE;
			done     <= 1'b0;
		end else begin
			done <= 1'b0;
			rv_q <= valid_q[rd_addr];
			unique case (state_q)
				D_IDLE: if (start) state_q <= D_WR;
				D_WR: begin
					valid_q[spos_q] <= 1'b1;
					state_q         <= D_RA;
				end
				D_RA: state_q <= D_RB;
				D_RB: state_q <= D_RC;
				D_RC: state_q <= D_CALC;
				D_CALC: begin
					inc_q <= INC_NONE;
					if (turn) up_q <= up_nx;
					if (pass && up_nx) begin
						valley_q <= this_i;
					end else if (pass) begin
						peak_q <= this_i;
						if (in_win) begin
							lo_q   <= lo_p[21:14];
							hi_q   <= (hi5 > 11'd255) ? 8'd255 : hi5[7:0];
							good_q <= good_nx;
							miss_q <= '0;
							if (good_nx > 4'd7) inc_q <= INC_ONE;
							else if (good_nx == 4'd7) inc_q <= INC_SEVEN;
						end else begin
							miss_q <= miss_nx;
							if (miss_nx > 8'd2) begin
								lo_q   <= cfg.interval_min;
								hi_q   <= cfg.interval_max;
								good_q <= '0;
							end
						end
					end
					spos_q  <= spos_nx;
					done    <= 1'b1;
					state_q <= D_IDLE;
				end
				default: state_q <= D_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == D_IDLE && start) sm_q <= smoothed;
		if (state_q == D_RA) prev_q <= rd_val;
		if (state_q == D_RB) pk_q <= rd_val;
		if (state_q == D_RC) vl_q <= rd_val;
	end

	assign step_increment = inc_q;

endmodule
`default_nettype wire

// ===== rtl/accel_step_counter_unit.sv =====
// Each input passes in order through the squaring of the three axes, the serial
// square root, the window sum and divide, the history reads and decision, and the
// output handoff; a new input is accepted only after the previous result is loaded.
// Reset (arst_n low, asynchronous): the smoothing ring, the history valid bits and
// the counters clear; the interval window and configuration registers return to
// 10 and 100, and the amplitude floor to 3.
`default_nettype none
module accel_step_counter_unit import asc_pkg::*; (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  s_tvalid,
	output logic                       s_tready,
	input  wire logic [47:0]           s_tdata,  // accel_x, accel_y, accel_z
	output logic                       m_tvalid,
	input  wire logic                  m_tready,
	output logic [71:0]                m_tdata,  // magnitude, smoothed, step_increment, step_total
	input  wire logic                  cfg_we,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_data
);

	typedef enum logic [4:0] {
		T_IDLE = 5'b00001,
		T_MAG  = 5'b00010,
		T_SM   = 5'b00100,
		T_DET  = 5'b01000,
		T_OUT  = 5'b10000
	} tstate_t;

	tstate_t     state_q;
	cfg_t        cfg_q;
	logic [31:0] total_q;
	logic        m_valid_q;
	logic [71:0] m_data_q;

	logic        accept;
	logic        mag_done, sm_done, det_done;
	logic [15:0] mag, sm;
	logic [2:0]  inc;
	logic        load;

	assign s_tready = (state_q == T_IDLE);
	assign accept   = s_tvalid && s_tready;
	assign load     = (state_q == T_OUT) && (!m_valid_q || m_tready);

	asc_mag u_mag (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (accept),
		.accel_x   (s_tdata[15:0]),
		.accel_y   (s_tdata[31:16]),
		.accel_z   (s_tdata[47:32]),
		.done      (mag_done),
		.magnitude (mag)
	);

	asc_smooth u_smooth (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (mag_done),
		.magnitude (mag),
		.done      (sm_done),
		.smoothed  (sm)
	);

	asc_detect u_detect (
		.clk            (clk),
		.arst_n         (arst_n),
		.start          (sm_done),
		.smoothed       (sm),
		.cfg            (cfg_q),
		.done           (det_done),
		.step_increment (inc)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q            <= T_IDLE;
			cfg_q.interval_min <= INTERVAL_MIN_RST;
			cfg_q.interval_max <= INTERVAL_MAX_RST;
			cfg_q.amp_floor    <= AMP_FLOOR_RST;
			total_q            <= '0;
			m_valid_q          <= 1'b0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					CFG_INTERVAL_MIN: cfg_q.interval_min <= cfg_data[7:0];
					CFG_INTERVAL_MAX: cfg_q.interval_max <= cfg_data[7:0];
					CFG_AMP_FLOOR:    cfg_q.amp_floor    <= cfg_data;
					default: ;
				endcase
			end
			unique case (state_q)
				T_IDLE:  if (accept) state_q <= T_MAG;
				T_MAG:   if (mag_done) state_q <= T_SM;
				T_SM:    if (sm_done) state_q <= T_DET;
				T_DET: begin
					if (det_done) begin
						total_q <= total_q + {29'd0, inc};
						state_q <= T_OUT;
					end
				end
				T_OUT:   if (load) state_q <= T_IDLE;
				default: state_q <= T_IDLE;
			endcase
			if (load) m_valid_q <= 1'b1;
			else if (m_tready) m_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) m_data_q <= {5'd0, total_q, inc, sm, mag};
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = m_data_q;

endmodule
`default_nettype wire

// ===== rtl/asc_checker.sv =====
`default_nettype none
module asc_checker import asc_pkg::*; (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        s_tvalid,
	input wire logic        s_tready,
	input wire logic        m_tvalid,
	input wire logic        m_tready,
	input wire logic [71:0] m_tdata
);

	// one item at a time: no second accept right after the first
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("input accepted while busy");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("stalled result changed");

	a_inc: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[34:32] == INC_NONE || m_tdata[34:32] == INC_ONE ||
		m_tdata[34:32] == INC_SEVEN))
		else $error("bad step increment");

	// total advances by exactly the increment of the next result
	a_total: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tready ##1 m_tvalid && $changed(m_tdata) |->
		m_tdata[66:35] == $past(m_tdata[66:35], 1) + {29'd0, m_tdata[34:32]} ||
		m_tdata[66:35] == $past(m_tdata[66:35], 2) + {29'd0, m_tdata[34:32]})
		else $error("step total out of sequence");

endmodule

bind accel_step_counter_unit asc_checker u_asc_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);
`default_nettype wire
